/* design/vca_pkg.sv */
`default_nettype none
package vca_pkg;

  // default sizing
  localparam int GRID_BITS_DEF  = 5;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_X     = 3'd0;
  localparam logic [2:0] REG_MIN_Y     = 3'd1;
  localparam logic [2:0] REG_MIN_Z     = 3'd2;
  localparam logic [2:0] REG_INV_SIZE  = 3'd3;
  localparam logic [2:0] REG_COLOR_EN  = 3'd4;

  // request function codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // latch request fields, clear scan offset
    logic mul;        // register axis products
    logic rd_add;     // read the target voxel, latch its index
    logic wr_add;     // accumulate into the target voxel
    logic scan_rd;    // read voxel at scan pointer + offset
    logic scan_hit;   // latch hit entry, clear it, start averaging
    logic scan_next;  // advance scan offset
    logic scan_miss;  // nothing occupied, rewind pointer
    logic div_step;   // one quotient bit per channel
    logic fin_add;    // present add result
    logic fin_emit;   // present emit result
    logic clr_step;   // clear one store entry
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic func;
    logic drop;
    logic hit;
    logic scan_last;
    logic div_last;
    logic clr_last;
  } status_t;

endpackage
`default_nettype wire

/* design/point_cloud_voxel_color_averager.sv */
`default_nettype none
// Channel   Signals                                         Handshake
// request   func pos_x/y/z red/green/blue_in                start & !busy
// result    cell_x/y/z avg_* point_count found dropped      done, one cycle
// config    cfg_index cfg_data                              cfg_we
//
// Add request: latch, multiply, voxel read, accumulate; a dropped point skips
// the voxel read and accumulate. Emit request: each voxel slot scanned takes a
// store read and a test, and a hit adds the 8-step averaging divider.
// After reset the store is cleared one entry per cycle with busy high; config
// writes are taken throughout.
// done cannot be held off: a result is valid only in its strobe cycle.
module point_cloud_voxel_color_averager #(
  parameter int GRID_BITS  = vca_pkg::GRID_BITS_DEF,
  parameter int COUNT_BITS = vca_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = vca_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire                 func,
  input  wire  signed [31:0]  pos_x,
  input  wire  signed [31:0]  pos_y,
  input  wire  signed [31:0]  pos_z,
  input  wire  [7:0]          red_in,
  input  wire  [7:0]          green_in,
  input  wire  [7:0]          blue_in,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [31:0]         cfg_data,
  output logic                done,
  output logic [4:0]          cell_x,
  output logic [4:0]          cell_y,
  output logic [4:0]          cell_z,
  output logic [7:0]          avg_red,
  output logic [7:0]          avg_green,
  output logic [7:0]          avg_blue,
  output logic [15:0]         point_count,
  output logic                found,
  output logic                dropped
);
  import vca_pkg::*;

  cmd_t    cmd;
  status_t status;

  vca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  vca_datapath #(
    .GRID_BITS  (GRID_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .done        (done),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .avg_red     (avg_red),
    .avg_green   (avg_green),
    .avg_blue    (avg_blue),
    .point_count (point_count),
    .found       (found),
    .dropped     (dropped)
  );

endmodule
`default_nettype wire

/* design/vca_ctrl.sv */
`default_nettype none
module vca_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  vca_pkg::status_t    status,
  output vca_pkg::cmd_t       cmd
);
  import vca_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MUL      = 4'd2;
  localparam logic [3:0] S_CHK      = 4'd3;
  localparam logic [3:0] S_ADD_WR   = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = status.func ? S_SCAN_RD : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (status.drop) begin
          cmd.fin_add = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_add = 1'b1;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.wr_add = 1'b1;
        cmd.fin_add = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (status.hit) begin
          cmd.scan_hit = 1'b1;
          state_next = S_DIV;
        end else if (status.scan_last) begin
          cmd.scan_miss = 1'b1;
          cmd.fin_emit = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin_emit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // at most one result per cycle, and results end a request
  a_one_fin: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_add || cmd.fin_emit) |=> (state == S_IDLE))
    else $error("result not followed by idle");

  a_fin_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fin_add, cmd.fin_emit, cmd.clr_step}))
    else $error("conflicting result commands");

  // no request taken during the clearing pass
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !cmd.load)
    else $error("request accepted while clearing");

endmodule
`default_nettype wire

/* design/vca_datapath.sv */
`default_nettype none
module vca_datapath #(
  parameter int GRID_BITS  = vca_pkg::GRID_BITS_DEF,
  parameter int COUNT_BITS = vca_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = vca_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  vca_pkg::cmd_t       cmd,
  output vca_pkg::status_t    status,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [31:0]         cfg_data,
  input  wire                 func,
  input  wire  signed [31:0]  pos_x,
  input  wire  signed [31:0]  pos_y,
  input  wire  signed [31:0]  pos_z,
  input  wire  [7:0]          red_in,
  input  wire  [7:0]          green_in,
  input  wire  [7:0]          blue_in,
  output logic                done,
  output logic [4:0]          cell_x,
  output logic [4:0]          cell_y,
  output logic [4:0]          cell_z,
  output logic [7:0]          avg_red,
  output logic [7:0]          avg_green,
  output logic [7:0]          avg_blue,
  output logic [15:0]         point_count,
  output logic                found,
  output logic                dropped
);
  import vca_pkg::*;

  localparam int ADDR_W = 3 * GRID_BITS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int SUM_W  = COUNT_BITS + 8;
  localparam int MEM_W  = COUNT_BITS + 3 * SUM_W;
  localparam int SHIFT  = 2 * FRAC_BITS;
  localparam int EXT_W  = (64 > SHIFT + GRID_BITS) ? 64 : SHIFT + GRID_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic signed [31:0] min_x, min_y, min_z;
  logic [31:0]        inv_voxel_size;
  logic               color_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      min_y <= '0;
      min_z <= '0;
      inv_voxel_size <= 32'd65536;
      color_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:    min_x <= cfg_data;
        REG_MIN_Y:    min_y <= cfg_data;
        REG_MIN_Z:    min_z <= cfg_data;
        REG_INV_SIZE: inv_voxel_size <= cfg_data;
        REG_COLOR_EN: color_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched request; the function bit steers the controller at accept time
  logic signed [31:0] px, py, pz;
  logic [7:0]         r_in, g_in, b_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      r_in <= red_in;
      g_in <= green_in;
      b_in <= blue_in;
    end
  end

  // offsets from the min corner, 33-bit signed
  logic [32:0] dx, dy, dz;
  assign dx = {px[31], px} - {min_x[31], min_x};
  assign dy = {py[31], py} - {min_y[31], min_y};
  assign dz = {pz[31], pz} - {min_z[31], min_z};

  // axis products, one multiplier per axis
  logic [63:0] prod_x, prod_y, prod_z;
  logic        neg_x, neg_y, neg_z;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x <= 64'(dx[31:0]) * 64'(inv_voxel_size);
      prod_y <= 64'(dy[31:0]) * 64'(inv_voxel_size);
      prod_z <= 64'(dz[31:0]) * 64'(inv_voxel_size);
      neg_x <= dx[32];
      neg_y <= dy[32];
      neg_z <= dz[32];
    end
  end

  // floor and range check per axis
  logic [EXT_W-1:0]     ex, ey, ez;
  logic [GRID_BITS-1:0] cx, cy, cz;
  logic                 inv_nz, out_x, out_y, out_z, drop;

  assign inv_nz = (inv_voxel_size != '0);
  assign ex = EXT_W'(prod_x);
  assign ey = EXT_W'(prod_y);
  assign ez = EXT_W'(prod_z);
  assign out_x = neg_x ? inv_nz : ((ex >> (SHIFT + GRID_BITS)) != '0);
  assign out_y = neg_y ? inv_nz : ((ey >> (SHIFT + GRID_BITS)) != '0);
  assign out_z = neg_z ? inv_nz : ((ez >> (SHIFT + GRID_BITS)) != '0);
  assign cx = neg_x ? '0 : ex[SHIFT +: GRID_BITS];
  assign cy = neg_y ? '0 : ey[SHIFT +: GRID_BITS];
  assign cz = neg_z ? '0 : ez[SHIFT +: GRID_BITS];
  assign drop = out_x | out_y | out_z;

  // scan pointer, offset and clear address
  logic [ADDR_W-1:0] scan_pointer, scan_off, clr_addr, idx, scan_addr, hit_addr;

  assign scan_addr = scan_pointer + scan_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pointer <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.scan_hit) scan_pointer <= scan_addr + 1'b1;
      else if (cmd.scan_miss) scan_pointer <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) scan_off <= '0;
    else if (cmd.scan_next) scan_off <= scan_off + 1'b1;
    if (cmd.rd_add) idx <= {cx, cy, cz};
    if (cmd.scan_hit) hit_addr <= scan_addr;
  end

  // voxel store: count and three color sums per entry
  logic [MEM_W-1:0]  mem [DEPTH];
  logic [MEM_W-1:0]  rdata, wdata;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic [SUM_W-1:0]      rd_r, rd_g, rd_b;
  assign {rd_cnt, rd_r, rd_g, rd_b} = rdata;

  assign raddr = cmd.rd_add ? {cx, cy, cz} : scan_addr;

  always_comb begin
    we = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.scan_hit) begin
      we = 1'b1;
      waddr = scan_addr;
    end else if (cmd.wr_add) begin
      we = (rd_cnt != COUNT_MAX);
      waddr = idx;
      wdata = {rd_cnt + 1'b1, rd_r + SUM_W'(r_in), rd_g + SUM_W'(g_in),
               rd_b + SUM_W'(b_in)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_add || cmd.scan_rd) rdata <= mem[raddr];
  end

  // restoring division, one quotient bit per step per channel
  logic [SUM_W:0]        rem_r, rem_g, rem_b;
  logic [SUM_W:0]        dsh;
  logic [7:0]            q_r, q_g, q_b;
  logic [2:0]            div_cnt;
  logic [COUNT_BITS-1:0] hit_cnt;

  always_ff @(posedge clk) begin
    if (cmd.scan_hit) begin
      hit_cnt <= rd_cnt;
      rem_r <= (SUM_W + 1)'(rd_r) + (SUM_W + 1)'(rd_cnt >> 1);
      rem_g <= (SUM_W + 1)'(rd_g) + (SUM_W + 1)'(rd_cnt >> 1);
      rem_b <= (SUM_W + 1)'(rd_b) + (SUM_W + 1)'(rd_cnt >> 1);
      dsh <= (SUM_W + 1)'(rd_cnt) << 7;
      div_cnt <= 3'd7;
      q_r <= '0;
      q_g <= '0;
      q_b <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) rem_r <= rem_r - dsh;
      if (rem_g >= dsh) rem_g <= rem_g - dsh;
      if (rem_b >= dsh) rem_b <= rem_b - dsh;
      q_r <= {q_r[6:0], rem_r >= dsh};
      q_g <= {q_g[6:0], rem_g >= dsh};
      q_b <= {q_b[6:0], rem_b >= dsh};
      dsh <= dsh >> 1;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign status.func      = func;
  assign status.drop      = drop;
  assign status.hit       = (rd_cnt != '0);
  assign status.scan_last = (scan_off == '1);
  assign status.div_last  = (div_cnt == '0);
  assign status.clr_last  = (clr_addr == '1);

  // result registers
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.fin_add | cmd.fin_emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_add) begin
      cell_x <= '0;
      cell_y <= '0;
      cell_z <= '0;
      avg_red <= '0;
      avg_green <= '0;
      avg_blue <= '0;
      point_count <= '0;
      found <= 1'b0;
      dropped <= drop;
    end else if (cmd.fin_emit) begin
      dropped <= 1'b0;
      if (cmd.scan_miss) begin
        cell_x <= '0;
        cell_y <= '0;
        cell_z <= '0;
        avg_red <= '0;
        avg_green <= '0;
        avg_blue <= '0;
        point_count <= '0;
        found <= 1'b0;
      end else begin
        cell_x <= 5'(hit_addr[2*GRID_BITS +: GRID_BITS]);
        cell_y <= 5'(hit_addr[GRID_BITS +: GRID_BITS]);
        cell_z <= 5'(hit_addr[0 +: GRID_BITS]);
        avg_red <= color_enable ? q_r : '0;
        avg_green <= color_enable ? q_g : '0;
        avg_blue <= color_enable ? q_b : '0;
        point_count <= 16'(hit_cnt);
        found <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
